@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Field widths
	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int PRES_W  = 32;
	localparam int TEMP_W  = 20;
	localparam int DT_W    = 25;
	localparam int CFG_IDX_W = 3;

	// Pipeline depth from the registered input stage to the result registers
	localparam int LATENCY = 10;

	// Compensation constants
	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
	// temp + 1500 written as q + 3500, with q = temp - 2000
	localparam logic signed [TEMP_W-1:0] COLD_OFS  = 20'sd3500;
	localparam logic signed [TEMP_W-1:0] COLD_LIM  = -20'sd3500;

	// Calibration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} cfg_reg_t;

endpackage

@@ sv/baro_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_pressure_compensation
// Second-order temperature compensation of raw barometric sensor conversions.
// ----------------------------------------------------------------------------
// Throughput: one sample pair per cycle; busy stays low, the receiver cannot
// stall and the pipeline never holds, so each stage simply advances.
// The rate is set by the ten-stage datapath with at most one multiply layer a stage.
// Reset (arst_n low) clears all valid bits and the six calibration words to 0.
// ----------------------------------------------------------------------------
module baro_pressure_compensation
	import bpc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        start,
	output logic                        busy,
	input  logic [RAW_W-1:0]            raw_pressure,
	input  logic [RAW_W-1:0]            raw_temperature,
	// result channel
	output logic                        done,
	output logic signed [PRES_W-1:0]    pressure,
	output logic signed [TEMP_W-1:0]    temperature,
	// calibration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [COEF_W-1:0]           cfg_data
);

	// ------------------------------------------------------------------
	// Calibration words
	// ------------------------------------------------------------------
	logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	assign cfg_ready = 1'b1;

	// Store a transfer; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_C1:  c1_q <= cfg_data;
				REG_C2:  c2_q <= cfg_data;
				REG_C3:  c3_q <= cfg_data;
				REG_C4:  c4_q <= cfg_data;
				REG_C5:  c5_q <= cfg_data;
				REG_C6:  c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline never holds
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Valid bits
	// ------------------------------------------------------------------
	logic [LATENCY-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: register D1 and dT = D2 - C5*256
	// ------------------------------------------------------------------
	logic [RAW_W-1:0]        d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [DT_W-1:0]  dt_s1;

	always_ff @(posedge clk) begin
		d1_s1 <= raw_pressure;
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'd0});
	end

	// ------------------------------------------------------------------
	// Stage 2: first-order products
	// ------------------------------------------------------------------
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	logic signed [49:0] pdd_s2;

	always_ff @(posedge clk) begin
		d1_s2  <= d1_s1;
		p6_s2  <= dt_s1 * $signed({1'b0, c6_q});
		p4_s2  <= dt_s1 * $signed({1'b0, c4_q});
		p3_s2  <= dt_s1 * $signed({1'b0, c3_q});
		pdd_s2 <= dt_s1 * dt_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: truncating scale, first-order TEMP, OFF, SENS and T2
	// ------------------------------------------------------------------
	logic signed [41:0] p6_adj, p4_adj, p3_adj;
	logic signed [18:0] q6;
	logic signed [34:0] q4;
	logic signed [33:0] q3;

	// Bias negative values so the arithmetic shift rounds toward zero
	assign p6_adj = p6_s2 + (p6_s2[41] ? 42'sd8388607 : 42'sd0);
	assign p4_adj = p4_s2 + (p4_s2[41] ? 42'sd127 : 42'sd0);
	assign p3_adj = p3_s2 + (p3_s2[41] ? 42'sd255 : 42'sd0);
	assign q6 = p6_adj[41:23];
	assign q4 = p4_adj[41:7];
	assign q3 = p3_adj[41:8];

	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [18:0]       lo_s3;
	logic signed [TEMP_W-1:0] vl_s3;
	logic                     cold_s3, frost_s3;
	logic signed [39:0]       off_s3, sens_s3;
	logic [16:0]              t2_s3;

	always_ff @(posedge clk) begin
		d1_s3    <= d1_s2;
		temp_s3  <= TEMP_BASE + {q6[18], q6};
		lo_s3    <= q6;
		vl_s3    <= {q6[18], q6} + COLD_OFS;
		cold_s3  <= q6[18];
		frost_s3 <= $signed({q6[18], q6}) < COLD_LIM;
		off_s3   <= $signed({8'd0, c2_q, 16'd0}) + {{5{q4[34]}}, q4};
		sens_s3  <= $signed({9'd0, c1_q, 15'd0}) + {{6{q3[33]}}, q3};
		// dT squared is never negative: a plain shift truncates
		t2_s3    <= pdd_s2[47:31];
	end

	// ------------------------------------------------------------------
	// Stage 4: squares and the T2 correction of TEMP
	// ------------------------------------------------------------------
	logic signed [37:0] sq_full;
	logic signed [39:0] sq2_full;
	assign sq_full  = lo_s3 * lo_s3;
	assign sq2_full = vl_s3 * vl_s3;

	logic [34:0]              sq_s4;
	logic [35:0]              sq2_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic                     cold_s4, frost_s4;
	logic signed [39:0]       off_s4, sens_s4;

	always_ff @(posedge clk) begin
		d1_s4    <= d1_s3;
		sq_s4    <= sq_full[34:0];
		sq2_s4   <= sq2_full[35:0];
		temp_s4  <= cold_s3 ? temp_s3 - $signed({3'd0, t2_s3}) : temp_s3;
		cold_s4  <= cold_s3;
		frost_s4 <= frost_s3;
		off_s4   <= off_s3;
		sens_s4  <= sens_s3;
	end

	// ------------------------------------------------------------------
	// Stage 5: OFF2 and SENS2 by shift-and-add constant multiples
	// ------------------------------------------------------------------
	logic [37:0] sq5;
	logic [38:0] sq2_x7;
	logic [39:0] sq2_x11;
	assign sq5     = {sq_s4, 2'd0} + {3'd0, sq_s4};
	assign sq2_x7  = {sq2_s4, 3'd0} - {3'd0, sq2_s4};
	assign sq2_x11 = {1'b0, sq2_s4, 3'd0} + {3'd0, sq2_s4, 1'd0} + {4'd0, sq2_s4};

	logic [40:0]              off2_s5, sens2_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic signed [39:0]       off_s5, sens_s5;

	always_ff @(posedge clk) begin
		d1_s5    <= d1_s4;
		temp_s5  <= temp_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		if (cold_s4) begin
			off2_s5  <= {4'd0, sq5[37:1]}
				+ (frost_s4 ? {2'd0, sq2_x7} : 41'd0);
			sens2_s5 <= {5'd0, sq5[37:2]}
				+ (frost_s4 ? {2'd0, sq2_x11[39:1]} : 41'd0);
		end else begin
			off2_s5  <= '0;
			sens2_s5 <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: final OFF and SENS
	// ------------------------------------------------------------------
	logic signed [TEMP_W-1:0] temp_s6;
	logic signed [41:0]       off_s6, sens_s6;

	always_ff @(posedge clk) begin
		d1_s6   <= d1_s5;
		temp_s6 <= temp_s5;
		off_s6  <= {{2{off_s5[39]}}, off_s5} - $signed({1'b0, off2_s5});
		sens_s6 <= {{2{sens_s5[39]}}, sens_s5} - $signed({1'b0, sens2_s5});
	end

	// ------------------------------------------------------------------
	// Stage 7: D1*SENS as two partial products
	// ------------------------------------------------------------------
	logic [44:0]              plo_s7;
	logic signed [45:0]       phi_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	logic signed [41:0]       off_s7;

	always_ff @(posedge clk) begin
		plo_s7  <= d1_s6 * sens_s6[20:0];
		phi_s7  <= $signed({1'b0, d1_s6}) * $signed(sens_s6[41:21]);
		temp_s7 <= temp_s6;
		off_s7  <= off_s6;
	end

	// ------------------------------------------------------------------
	// Stage 8: combine the partial products
	// ------------------------------------------------------------------
	logic signed [66:0]       phi_sh;
	logic signed [63:0]       prod_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	logic signed [41:0]       off_s8;
	assign phi_sh = {phi_s7, 21'd0};

	always_ff @(posedge clk) begin
		prod_s8 <= phi_sh[63:0] + $signed({19'd0, plo_s7});
		temp_s8 <= temp_s7;
		off_s8  <= off_s7;
	end

	// ------------------------------------------------------------------
	// Stage 9: D1*SENS/2^21 - OFF
	// ------------------------------------------------------------------
	logic signed [63:0]       prod_adj;
	logic signed [42:0]       ps;
	logic signed [43:0]       x_s9;
	logic signed [TEMP_W-1:0] temp_s9;
	assign prod_adj = prod_s8 + (prod_s8[63] ? 64'sd2097151 : 64'sd0);
	assign ps       = prod_adj[63:21];

	always_ff @(posedge clk) begin
		x_s9    <= {ps[42], ps} - {{2{off_s8[41]}}, off_s8};
		temp_s9 <= temp_s8;
	end

	// ------------------------------------------------------------------
	// Stage 10: /2^15 into the result registers
	// ------------------------------------------------------------------
	// The quotient spans 29 bits, so it always fits the 32-bit result without a clamp.
	logic signed [43:0] x_adj;
	logic signed [28:0] pq;
	assign x_adj = x_s9 + (x_s9[43] ? 44'sd32767 : 44'sd0);
	assign pq    = x_adj[43:15];

	always_ff @(posedge clk) begin
		pressure    <= {{(PRES_W-29){pq[28]}}, pq};
		temperature <= temp_s9;
	end

	assign done = vld_q[LATENCY-1];

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// Every accepted sample leaves the pipeline as a done strobe
	a_lat_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> ##(LATENCY-1) done)
		else $error("sample lost in pipeline");

	a_lat_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[0], LATENCY-1))
		else $error("result without a matching sample");

	// A start transfer is always followed by a result strobe
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##(LATENCY-1) done)
		else $error("start transfer produced no result");

endmodule
